// ===== sv/scht_pkg.sv =====
// Shared types and constants for the sphere/capsule hit test pipeline.
package scht_pkg;

    // Number of pipeline stages in each half and in the whole block
    localparam int unsigned FRONT_STAGES = 3;
    localparam int unsigned BACK_STAGES  = 3;
    localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + BACK_STAGES;

    // Where the sphere center projects onto the capsule axis
    typedef enum logic [2:0] {
        SEG_TOP    = 3'b001,
        SEG_BOTTOM = 3'b010,
        SEG_MID    = 3'b100
    } seg_region_t;

endpackage

// ===== sv/sphere_capsule_hit_test.sv =====
// Top level: sphere against capsule overlap test, one word per cycle while the output is not stalled.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | sphere center, radius, axis ends, capsule radius
//  m_      | out | m_valid / m_ready  | m_hit
//
// Each word passes through the front half and then the back half.
// A new word is taken every cycle while the output is free or being taken.
// A stall on m_ready freezes every stage at once; nothing is dropped or repeated.
// Reset clears the valid bits only; the data path needs no reset.
module sphere_capsule_hit_test #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_sphere_x,
    input  logic signed [COORD_WIDTH-1:0] s_sphere_y,
    input  logic signed [COORD_WIDTH-1:0] s_sphere_z,
    input  logic        [COORD_WIDTH-2:0] s_sphere_radius,
    input  logic signed [COORD_WIDTH-1:0] s_top_x,
    input  logic signed [COORD_WIDTH-1:0] s_top_y,
    input  logic signed [COORD_WIDTH-1:0] s_top_z,
    input  logic signed [COORD_WIDTH-1:0] s_bottom_x,
    input  logic signed [COORD_WIDTH-1:0] s_bottom_y,
    input  logic signed [COORD_WIDTH-1:0] s_bottom_z,
    input  logic        [COORD_WIDTH-2:0] s_capsule_radius,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit
);
    import scht_pkg::*;

    localparam int unsigned SW = 2 * COORD_WIDTH + 4;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic                  advance;

    logic signed [SW-1:0]            dot, len2, vv, ww;
    logic        [2*COORD_WIDTH-1:0] r2;

    // Move the whole pipe unless the last word is stuck
    assign advance = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = advance;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    // Shift the valid bits along with the data
    always_comb begin
        vld_next = vld_reg;
        if (advance) begin
            vld_next = {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    scht_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .en             (advance),
        .sphere_x       (s_sphere_x),
        .sphere_y       (s_sphere_y),
        .sphere_z       (s_sphere_z),
        .sphere_radius  (s_sphere_radius),
        .top_x          (s_top_x),
        .top_y          (s_top_y),
        .top_z          (s_top_z),
        .bottom_x       (s_bottom_x),
        .bottom_y       (s_bottom_y),
        .bottom_z       (s_bottom_z),
        .capsule_radius (s_capsule_radius),
        .dot            (dot),
        .len2           (len2),
        .vv             (vv),
        .ww             (ww),
        .r2             (r2)
    );

    scht_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .aclk (aclk),
        .en   (advance),
        .dot  (dot),
        .len2 (len2),
        .vv   (vv),
        .ww   (ww),
        .r2   (r2),
        .hit  (m_hit)
    );

    // Pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // An accepted word lands in the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word lost at pipe entry");

    // A stalled result holds its value and its place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(vld_reg))
        else $error("stalled pipe moved");

endmodule

// ===== sv/scht_front.sv =====
// Front half: axis differences, coordinate products and dot-product sums.
module scht_front #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [COORD_WIDTH-1:0]  sphere_x,
    input  logic signed [COORD_WIDTH-1:0]  sphere_y,
    input  logic signed [COORD_WIDTH-1:0]  sphere_z,
    input  logic        [COORD_WIDTH-2:0]  sphere_radius,
    input  logic signed [COORD_WIDTH-1:0]  top_x,
    input  logic signed [COORD_WIDTH-1:0]  top_y,
    input  logic signed [COORD_WIDTH-1:0]  top_z,
    input  logic signed [COORD_WIDTH-1:0]  bottom_x,
    input  logic signed [COORD_WIDTH-1:0]  bottom_y,
    input  logic signed [COORD_WIDTH-1:0]  bottom_z,
    input  logic        [COORD_WIDTH-2:0]  capsule_radius,
    output logic signed [2*COORD_WIDTH+3:0] dot,
    output logic signed [2*COORD_WIDTH+3:0] len2,
    output logic signed [2*COORD_WIDTH+3:0] vv,
    output logic signed [2*COORD_WIDTH+3:0] ww,
    output logic        [2*COORD_WIDTH-1:0] r2
);
    import scht_pkg::*;

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned SW = PW + 2;

    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic        [COORD_WIDTH-1:0] rsum_reg;

    logic signed [PW-1:0] dv_reg [3];
    logic signed [PW-1:0] dd_reg [3];
    logic signed [PW-1:0] vv_reg [3];
    logic signed [PW-1:0] ww_reg [3];
    logic        [2*COORD_WIDTH-1:0] r2_reg;

    logic signed [SW-1:0] dot_reg, len2_reg, vvs_reg, wws_reg;
    logic        [2*COORD_WIDTH-1:0] r2_out_reg;

    logic signed [COORD_WIDTH-1:0] s_c [3];
    logic signed [COORD_WIDTH-1:0] t_c [3];
    logic signed [COORD_WIDTH-1:0] b_c [3];

    assign s_c = '{sphere_x, sphere_y, sphere_z};
    assign t_c = '{top_x, top_y, top_z};
    assign b_c = '{bottom_x, bottom_y, bottom_z};

    function automatic logic signed [SW-1:0] sum3(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b,
        input logic signed [PW-1:0] c
    );
        return SW'(a) + SW'(b) + SW'(c);
    endfunction

    // Stage 1: differences against the axis ends, radius sum
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v_reg[i] <= DW'(s_c[i]) - DW'(t_c[i]);
                d_reg[i] <= DW'(b_c[i]) - DW'(t_c[i]);
                w_reg[i] <= DW'(s_c[i]) - DW'(b_c[i]);
            end
            rsum_reg <= COORD_WIDTH'(sphere_radius) + COORD_WIDTH'(capsule_radius);
        end
    end

    // Stage 2: one multiplier per coordinate term
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv_reg[i] <= d_reg[i] * v_reg[i];
                dd_reg[i] <= d_reg[i] * d_reg[i];
                vv_reg[i] <= v_reg[i] * v_reg[i];
                ww_reg[i] <= w_reg[i] * w_reg[i];
            end
            r2_reg <= rsum_reg * rsum_reg;
        end
    end

    // Stage 3: sum the coordinate terms
    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg    <= sum3(dv_reg[0], dv_reg[1], dv_reg[2]);
            len2_reg   <= sum3(dd_reg[0], dd_reg[1], dd_reg[2]);
            vvs_reg    <= sum3(vv_reg[0], vv_reg[1], vv_reg[2]);
            wws_reg    <= sum3(ww_reg[0], ww_reg[1], ww_reg[2]);
            r2_out_reg <= r2_reg;
        end
    end

    assign dot  = dot_reg;
    assign len2 = len2_reg;
    assign vv   = vvs_reg;
    assign ww   = wws_reg;
    assign r2   = r2_out_reg;

endmodule

// ===== sv/scht_back.sv =====
// Back half: segment region, split wide products and the final compare.
module scht_back #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [2*COORD_WIDTH+3:0] dot,
    input  logic signed [2*COORD_WIDTH+3:0] len2,
    input  logic signed [2*COORD_WIDTH+3:0] vv,
    input  logic signed [2*COORD_WIDTH+3:0] ww,
    input  logic        [2*COORD_WIDTH-1:0] r2,
    output logic                            hit
);
    import scht_pkg::*;

    localparam int unsigned SW   = 2 * COORD_WIDTH + 4;
    localparam int unsigned UW   = SW - 1;
    localparam int unsigned LO_W = (UW + 1) / 2;
    localparam int unsigned XW   = 2 * UW;
    localparam int unsigned XW1  = XW + 1;

    logic [UW-1:0] vv_u, len2_u, dot_u, r2_u, ww_u;

    seg_region_t region_next;
    seg_region_t region4_reg, region5_reg;
    logic        end_hit4_reg, end_hit5_reg;

    // Partial products: [0]=lo*lo [1]=lo*hi [2]=hi*lo [3]=hi*hi
    logic [2*LO_W-1:0] vl_pp_reg [4];
    logic [2*LO_W-1:0] dd_pp_reg [4];
    logic [2*LO_W-1:0] rl_pp_reg [4];

    logic [XW-1:0] vl_reg, dd_reg, rl_reg;
    logic          hit_reg;

    assign vv_u   = vv[UW-1:0];
    assign ww_u   = ww[UW-1:0];
    assign len2_u = len2[UW-1:0];
    assign dot_u  = dot[UW-1:0];
    assign r2_u   = UW'(r2);

    function automatic logic [XW-1:0] join_pp(
        input logic [2*LO_W-1:0] ll,
        input logic [2*LO_W-1:0] lh,
        input logic [2*LO_W-1:0] hl,
        input logic [2*LO_W-1:0] hh
    );
        return XW'(ll) + (XW'(lh) << LO_W) + (XW'(hl) << LO_W) + (XW'(hh) << (2 * LO_W));
    endfunction

    // Pick the closest axis point: top end, bottom end or inside the segment
    always_comb begin
        if (len2 == '0 || dot[SW-1] || dot == '0) begin
            region_next = SEG_TOP;
        end else if (dot >= len2) begin
            region_next = SEG_BOTTOM;
        end else begin
            region_next = SEG_MID;
        end
    end

    // Stage 4: region, endpoint distance test, partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            region4_reg  <= region_next;
            end_hit4_reg <= (region_next == SEG_BOTTOM) ? (ww_u < r2_u) : (vv_u < r2_u);
            vl_pp_reg[0] <= vv_u[LO_W-1:0] * len2_u[LO_W-1:0];
            vl_pp_reg[1] <= vv_u[LO_W-1:0] * LO_W'(len2_u[UW-1:LO_W]);
            vl_pp_reg[2] <= LO_W'(vv_u[UW-1:LO_W]) * len2_u[LO_W-1:0];
            vl_pp_reg[3] <= LO_W'(vv_u[UW-1:LO_W]) * LO_W'(len2_u[UW-1:LO_W]);
            dd_pp_reg[0] <= dot_u[LO_W-1:0] * dot_u[LO_W-1:0];
            dd_pp_reg[1] <= dot_u[LO_W-1:0] * LO_W'(dot_u[UW-1:LO_W]);
            dd_pp_reg[2] <= LO_W'(dot_u[UW-1:LO_W]) * dot_u[LO_W-1:0];
            dd_pp_reg[3] <= LO_W'(dot_u[UW-1:LO_W]) * LO_W'(dot_u[UW-1:LO_W]);
            rl_pp_reg[0] <= r2_u[LO_W-1:0] * len2_u[LO_W-1:0];
            rl_pp_reg[1] <= r2_u[LO_W-1:0] * LO_W'(len2_u[UW-1:LO_W]);
            rl_pp_reg[2] <= LO_W'(r2_u[UW-1:LO_W]) * len2_u[LO_W-1:0];
            rl_pp_reg[3] <= LO_W'(r2_u[UW-1:LO_W]) * LO_W'(len2_u[UW-1:LO_W]);
        end
    end

    // Stage 5: assemble the full-width products
    always_ff @(posedge aclk) begin
        if (en) begin
            region5_reg  <= region4_reg;
            end_hit5_reg <= end_hit4_reg;
            vl_reg <= join_pp(vl_pp_reg[0], vl_pp_reg[1], vl_pp_reg[2], vl_pp_reg[3]);
            dd_reg <= join_pp(dd_pp_reg[0], dd_pp_reg[1], dd_pp_reg[2], dd_pp_reg[3]);
            rl_reg <= join_pp(rl_pp_reg[0], rl_pp_reg[1], rl_pp_reg[2], rl_pp_reg[3]);
        end
    end

    // Stage 6: inside the segment, vv*len2 - dot^2 < r2*len2
    always_ff @(posedge aclk) begin
        if (en) begin
            if (region5_reg == SEG_MID) begin
                hit_reg <= XW1'(vl_reg) < (XW1'(rl_reg) + XW1'(dd_reg));
            end else begin
                hit_reg <= end_hit5_reg;
            end
        end
    end

    assign hit = hit_reg;

endmodule

// ===== test/sphere_capsule_hit_test_tb.sv =====
// Testbench for the sphere/capsule hit test pipeline: random and directed pairs, scoreboard check.
`timescale 1ns / 100ps

module sphere_capsule_hit_test_tb;
    import scht_pkg::*;

    localparam int CW = 32;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] sx, sy, sz;
        logic [CW-2:0]        rs;
        logic signed [CW-1:0] tx, ty, tz;
        logic signed [CW-1:0] bx, by, bz;
        logic [CW-2:0]        rc;
    } pair_t;

    // Exact overlap decision on 256-bit signed integers
    function automatic bit overlap_of(pair_t p);
        logic signed [255:0] v[3], d[3], w[3];
        logic signed [255:0] dotp, len2, vv, ww, rsum, r2;
        v[0] = 256'(p.sx) - 256'(p.tx);
        v[1] = 256'(p.sy) - 256'(p.ty);
        v[2] = 256'(p.sz) - 256'(p.tz);
        d[0] = 256'(p.bx) - 256'(p.tx);
        d[1] = 256'(p.by) - 256'(p.ty);
        d[2] = 256'(p.bz) - 256'(p.tz);
        w[0] = 256'(p.sx) - 256'(p.bx);
        w[1] = 256'(p.sy) - 256'(p.by);
        w[2] = 256'(p.sz) - 256'(p.bz);
        rsum = $signed({225'd0, p.rs}) + $signed({225'd0, p.rc});
        r2 = rsum * rsum;
        dotp = d[0]*v[0] + d[1]*v[1] + d[2]*v[2];
        len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
        vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        ww = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
        if (len2 == 0 || dotp <= 0)
            return vv < r2;
        if (dotp >= len2)
            return ww < r2;
        return (vv*len2 - dotp*dotp) < r2*len2;
    endfunction

    class hit_scoreboard;
        bit pending_hits[$];
        int mismatches;

        function void note_pair(pair_t p);
            pending_hits = {pending_hits, overlap_of(p)};
        endfunction

        function void check_hit(logic h);
            bit want;
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: hit=%b", h);
                return;
            end
            want = pending_hits.pop_front();
            if (h !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("hit: expected %b, actual %b", want, h);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 0;
    logic m_hit;
    pair_t cur = '{default: '0};
    int send_idle = 22, recv_idle = 54;
    int hold_off = 0;
    longint cycles = 0;
    hit_scoreboard sb = new();

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    sphere_capsule_hit_test #(.COORD_WIDTH(CW)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sphere_x(cur.sx), .s_sphere_y(cur.sy), .s_sphere_z(cur.sz),
        .s_sphere_radius(cur.rs),
        .s_top_x(cur.tx), .s_top_y(cur.ty), .s_top_z(cur.tz),
        .s_bottom_x(cur.bx), .s_bottom_y(cur.by), .s_bottom_z(cur.bz),
        .s_capsule_radius(cur.rc),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit)
    );

    // Check each accepted result word and drive m_ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_hit(m_hit);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sphere_capsule_hit_test: mismatch");
            $finish;
        end
    end

    // Offer one word, dropping valid during a random gap first, and wait for acceptance
    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        cur <= p;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_pair(p);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $signed(CW'($urandom));
            1: return $signed(CW'(int'($urandom_range(2000)) - 1000));
            default: return $signed(CW'((int'($urandom_range(400)) - 200) <<< 16));
        endcase
    endfunction

    // Random pair, mostly at geometric scale so hits and misses both occur
    function automatic pair_t rand_pair();
        pair_t p;
        int m, k;
        m = ($urandom_range(9) == 0) ? 0 : 2;
        p.tx = rand_coord(m); p.ty = rand_coord(m); p.tz = rand_coord(m);
        k = $urandom_range(9);
        if (k == 0) begin
            p.bx = p.tx; p.by = p.ty; p.bz = p.tz;
        end else begin
            p.bx = rand_coord(m); p.by = rand_coord(m); p.bz = rand_coord(m);
        end
        p.sx = rand_coord(m); p.sy = rand_coord(m); p.sz = rand_coord(m);
        if (m == 0) begin
            p.rs = (CW-1)'($urandom); p.rc = (CW-1)'($urandom);
        end else begin
            p.rs = (CW-1)'($urandom_range(150) << 16 | $urandom_range(65535));
            p.rc = (CW-1)'($urandom_range(150) << 16 | $urandom_range(65535));
        end
        return p;
    endfunction

    function automatic pair_t mk(int sx, int sy, int sz, int rs, int tx, int ty, int tz,
                                 int bx, int by, int bz, int rc);
        pair_t p;
        p.sx = sx; p.sy = sy; p.sz = sz; p.rs = (CW-1)'(rs);
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.bx = bx; p.by = by; p.bz = bz; p.rc = (CW-1)'(rc);
        return p;
    endfunction

    task automatic run_phase(int n, int si, int ri);
        send_idle = si;
        recv_idle = ri;
        repeat (n)
            send_pair(rand_pair());
    endtask

    localparam int MAXP = 32'h7fffffff;
    localparam int MINN = 32'h80000000;

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: before top, at top, beyond/at bottom, mid, zero axis, touching
        send_pair(mk(0, -5, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(0, -4, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(3, 0, 0, 1, 0, 0, 0, 0, 10, 0, 1));
        send_pair(mk(3, 0, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(0, 14, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(0, 13, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(2, 10, 0, 1, 0, 0, 0, 0, 10, 0, 1));
        send_pair(mk(3, 10, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(3, 5, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(4, 5, 0, 2, 0, 0, 0, 0, 10, 0, 2));
        send_pair(mk(3, 4, 0, 1, 7, 7, 7, 7, 7, 7, 3));
        send_pair(mk(3, 4, 0, 3, 0, 0, 0, 0, 0, 0, 2));
        send_pair(mk(MAXP, MAXP, MAXP, MAXP, MINN, MINN, MINN, MAXP, MINN, MAXP, MAXP));
        send_pair(mk(MINN, MINN, MINN, 0, MAXP, MAXP, MAXP, MINN, MAXP, MINN, 0));
        send_pair(mk(MINN, MAXP, 0, MAXP, MAXP, MINN, 0, MAXP, MINN, 0, MAXP));
        send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(mk(-1, -1, -1, MAXP, 0, 0, 0, -1, -1, -1, 0));
        send_pair(mk(MAXP, 0, 0, 1, MINN, 0, 0, MAXP, 0, 0, 0));

        // Long receiver hold-off while words keep coming
        hold_off = 60;
        send_idle = 0;
        repeat (20)
            send_pair(rand_pair());

        run_phase(230, 22, 54);
        run_phase(230, 54, 22);
        run_phase(220, 0, 0);
        s_valid <= 0;

        // Drain
        while (sb.pending_hits.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("sphere_capsule_hit_test: match");
        else
            $display("sphere_capsule_hit_test: mismatch");
        $finish;
    end
endmodule
